>>> sv/aws_pkg.sv
// ============================================================================
// aws_pkg: shared types and constants of the area-weighted entry sampler
// Holds the request and status codes, the controller state type and the
// fixed field widths used by the datapath units and the top level.
// ============================================================================
package aws_pkg;

    // Fixed widths of the transaction fields.
    localparam int REQ_W        = 2;
    localparam int STAT_W       = 2;
    localparam int IDX_OUT_W    = 8;
    localparam int CNT_OUT_W    = 9;
    localparam int U_BITS       = 32;
    localparam int IN_AREA_BITS = 32;

    // The scaling multiplier consumes the total in chunks of this many bits.
    localparam int CHUNK_BITS = 16;

    // The remap divider produces this many quotient bits, one per cycle.
    localparam int Q_BITS = 32;
    localparam int QCW    = $clog2(Q_BITS);

    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [STAT_W-1:0] t_status;

    // Request kinds.
    localparam t_req REQ_CLEAR  = 2'd0;
    localparam t_req REQ_APPEND = 2'd1;
    localparam t_req REQ_SAMPLE = 2'd2;

    // Result status codes.
    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_FULL      = 2'd1;
    localparam t_status STAT_EMPTY     = 2'd2;
    localparam t_status STAT_ZERO_AREA = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

>>> sv/aws_prefix_ram.sv
// ============================================================================
// aws_prefix_ram: prefix-sum table storage
// Simple dual-port synchronous memory: one write port and one read port with
// registered read data.
// ============================================================================
module aws_prefix_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/aws_scale_mul.sv
// ============================================================================
// aws_scale_mul: scales a Q0.32 value by the total area
// Computes floor(u * total / 2^32) with one 32x16 partial product per cycle,
// accumulated most significant chunk first.
// ============================================================================
module aws_scale_mul #(
    parameter int PW = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [aws_pkg::U_BITS-1:0]  i_u,
    input  logic [PW-1:0]               i_total,
    output logic                        o_done,
    output logic [PW-1:0]               o_scaled
);
    import aws_pkg::*;

    localparam int NCH = (PW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int TP  = NCH * CHUNK_BITS;
    localparam int ACW = U_BITS + TP;
    localparam int PRW = U_BITS + CHUNK_BITS;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

    logic              r_issue;
    logic              r_pv;
    logic              r_done;
    logic [KW-1:0]     r_k;
    logic [U_BITS-1:0] r_u;
    logic [TP-1:0]     r_tot;
    logic [PRW-1:0]    r_prod;
    logic [ACW-1:0]    r_acc;
    logic [ACW-1:0]    n_acc;

    // Horner step: shift the running sum by one chunk and add the product.
    assign n_acc = (r_acc << CHUNK_BITS) + ACW'(r_prod);

    // Sequencing of chunk issue, product valid and completion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_issue <= 1'b1;
                r_pv    <= 1'b0;
            end else begin
                r_pv <= r_issue;
                if (r_issue && (r_k == '0)) begin
                    r_issue <= 1'b0;
                end
                if (r_pv && !r_issue) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands, partial product and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u   <= i_u;
            r_tot <= TP'(i_total);
            r_k   <= KW'(NCH - 1);
            r_acc <= '0;
        end else begin
            if (r_issue) begin
                r_prod <= PRW'(r_u) * PRW'(r_tot[r_k*CHUNK_BITS +: CHUNK_BITS]);
                if (r_k != '0) begin
                    r_k <= r_k - KW'(1);
                end
            end
            if (r_pv) begin
                r_acc <= n_acc;
            end
        end
    end

    assign o_done   = r_done;
    assign o_scaled = r_acc[U_BITS +: PW];

endmodule

>>> sv/aws_divider.sv
// ============================================================================
// aws_divider: remap divider
// Restoring division giving floor(num * 2^32 / den) for num below den, one
// quotient bit per cycle.
// ============================================================================
module aws_divider #(
    parameter int PW = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [PW-1:0]              i_num,
    input  logic [PW-1:0]              i_den,
    output logic                       o_done,
    output logic [aws_pkg::Q_BITS-1:0] o_quot
);
    import aws_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCW-1:0]    r_step;
    logic [PW-1:0]     r_rem;
    logic [PW-1:0]     r_den;
    logic [Q_BITS-1:0] r_quot;
    logic [PW:0]       shifted;
    logic [PW:0]       diff;
    logic              ge;

    // One restoring step: shift in a zero and try to subtract the divisor.
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = (shifted >= {1'b0, r_den});

    // Busy flag and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == QCW'(Q_BITS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Partial remainder, divisor and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[PW-1:0] : shifted[PW-1:0];
            r_quot <= {r_quot[Q_BITS-2:0], ge};
            r_step <= r_step + QCW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> sv/area_weighted_entry_sampler.sv
// ============================================================================
// area_weighted_entry_sampler: discrete CDF inversion over entry areas
// Keeps running prefix sums of entry areas in a memory and draws entries
// with probability proportional to their area.
// ============================================================================
// Usage:
// One input channel (i_in_valid / o_in_stall) carries a request: clear the
// table, append one area, or sample with a Q0.32 uniform value. Every input
// transaction gives exactly one output transaction (o_out_valid /
// i_out_stall) with the chosen index, the remapped sample, the entry count
// and a status code.
// One item is worked on at a time. A clear, an append, or a sample on an empty
// table or zero total goes from the accepting cycle straight to the hand-over
// of its result. Any other sample goes on through the chunked multiply by the
// total, binary-search probes through the prefix memory's registered read port
// (read and compare states each), states to close the search and to check the
// entry, the bit-serial remap divider if the offset lies inside a nonempty
// entry, and the hand-over. The result sits in an output register, so the next
// item is taken while a result is still stalled; a finished result waits in
// the controller until the output register is free. Reset empties the table
// at once (count and total to zero) without a clearing pass.
// ============================================================================
module area_weighted_entry_sampler #(
    parameter int MAX_ENTRIES = 256,
    parameter int AREA_BITS   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [aws_pkg::REQ_W-1:0]        i_req_type,
    input  logic [aws_pkg::IN_AREA_BITS-1:0] i_entry_area,
    input  logic [aws_pkg::U_BITS-1:0]       i_uniform_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [aws_pkg::IDX_OUT_W-1:0]    o_chosen_index,
    output logic [aws_pkg::Q_BITS-1:0]       o_remapped_sample,
    output logic [aws_pkg::CNT_OUT_W-1:0]    o_entry_count,
    output logic [aws_pkg::STAT_W-1:0]       o_status
);
    import aws_pkg::*;

    localparam int AW = (AREA_BITS < IN_AREA_BITS) ? AREA_BITS : IN_AREA_BITS;
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = AW + IW;

    // Control and working registers.
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     r_total, n_total;
    logic              r_out_valid, n_out_valid;
    logic [PW-1:0]     r_scaled, n_scaled;
    logic [IW-1:0]     r_lo, n_lo;
    logic [IW-1:0]     r_hi, n_hi;
    logic [IW-1:0]     r_mid, n_mid;
    logic [PW-1:0]     r_start, n_start;
    logic [PW-1:0]     r_end, n_end;
    logic [PW-1:0]     r_area, n_area;
    logic [PW-1:0]     r_rem, n_rem;
    logic [IW-1:0]     r_res_idx, n_res_idx;
    logic [Q_BITS-1:0] r_res_q, n_res_q;
    t_status           r_res_status, n_res_status;
    logic [IW-1:0]     r_out_idx, n_out_idx;
    logic [Q_BITS-1:0] r_out_q, n_out_q;
    logic [CW-1:0]     r_out_count, n_out_count;
    t_status           r_out_status, n_out_status;

    // Datapath signals.
    logic              out_free;
    logic              full;
    logic [PW-1:0]     app_total;
    logic [CW-1:0]     cnt_m1;
    logic [IW:0]       mid_sum;
    logic [IW-1:0]     mid;
    logic [IW-1:0]     mid_m1;
    logic              mem_we;
    logic [PW-1:0]     mem_rdata;
    logic              mul_start;
    logic              mul_done;
    logic [PW-1:0]     mul_scaled;
    logic              div_start;
    logic              div_done;
    logic [Q_BITS-1:0] div_quot;

    // Prefix-sum memory: written on append, read by the search.
    aws_prefix_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IW),
        .DATA_W (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (app_total),
        .i_raddr (mid_m1),
        .o_rdata (mem_rdata)
    );

    // Scaling of the uniform value by the total area.
    aws_scale_mul #(
        .PW (PW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_u      (i_uniform_sample),
        .i_total  (r_total),
        .o_done   (mul_done),
        .o_scaled (mul_scaled)
    );

    // Remap of the offset inside the chosen entry.
    aws_divider #(
        .PW (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_rem),
        .i_den   (r_area),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Shared arithmetic.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign full      = (r_count == CW'(MAX_ENTRIES));
    assign app_total = r_total + PW'(i_entry_area[AW-1:0]);
    assign cnt_m1    = r_count - CW'(1);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi} + (IW+1)'(1);
    assign mid       = mid_sum[IW:1];
    assign mid_m1    = mid - IW'(1);

    // Next-state and datapath control.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_out_valid  = r_out_valid;
        n_scaled     = r_scaled;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_start      = r_start;
        n_end        = r_end;
        n_area       = r_area;
        n_rem        = r_rem;
        n_res_idx    = r_res_idx;
        n_res_q      = r_res_q;
        n_res_status = r_res_status;
        n_out_idx    = r_out_idx;
        n_out_q      = r_out_q;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mul_start    = 1'b0;
        div_start    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_idx    = '0;
                    n_res_q      = '0;
                    n_res_status = STAT_OK;
                    n_state      = ST_EMIT;
                    unique case (i_req_type)
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                        end
                        REQ_APPEND: begin
                            if (full) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_total = app_total;
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_SAMPLE: begin
                            if ((r_count == '0) || (r_total == '0)) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                mul_start = 1'b1;
                                n_state   = ST_MUL;
                            end
                        end
                        default: begin
                            // Unknown request kind: no-op with an OK result.
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_scaled = mul_scaled;
                    n_lo     = '0;
                    n_hi     = cnt_m1[IW-1:0];
                    n_start  = '0;
                    n_end    = r_total;
                    n_state  = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                // Search done: the end of the found entry is the last end seen.
                if (r_lo == r_hi) begin
                    n_area  = r_end - r_start;
                    n_rem   = (r_scaled >= r_start) ? (r_scaled - r_start) : '0;
                    n_state = ST_CHECK;
                end else begin
                    n_mid   = mid;
                    n_state = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                // The read value is the start of entry mid.
                if (mem_rdata <= r_scaled) begin
                    n_lo    = r_mid;
                    n_start = mem_rdata;
                end else begin
                    n_hi  = r_mid - IW'(1);
                    n_end = mem_rdata;
                end
                n_state = ST_SRCH_RD;
            end
            ST_CHECK: begin
                n_res_idx = r_lo;
                if (r_area == '0) begin
                    n_res_status = STAT_ZERO_AREA;
                    n_state      = ST_EMIT;
                end else if (r_rem >= r_area) begin
                    n_res_q = '1;
                    n_state = ST_EMIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_res_q = div_quot;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_res_idx;
                    n_out_q      = r_res_q;
                    n_out_count  = r_count;
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_scaled     <= n_scaled;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_start      <= n_start;
        r_end        <= n_end;
        r_area       <= n_area;
        r_rem        <= n_rem;
        r_res_idx    <= n_res_idx;
        r_res_q      <= n_res_q;
        r_res_status <= n_res_status;
        r_out_idx    <= n_out_idx;
        r_out_q      <= n_out_q;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    // Port outputs.
    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_chosen_index    = IDX_OUT_W'(r_out_idx);
    assign o_remapped_sample = r_out_q;
    assign o_entry_count     = CNT_OUT_W'(r_out_count);
    assign o_status          = r_out_status;

`ifndef SYNTHESIS
    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    // An accepted transaction keeps the input stalled until its result is out.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // Any failure status comes with a zero remapped sample.
    a_fail_zero_remap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_OK)) |-> (o_remapped_sample == '0))
        else $error("nonzero remapped sample on a failed transaction");

    // A search probe is only issued while the range still holds at least two entries.
    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH_CMP) |-> (r_lo < r_hi))
        else $error("search probe with an empty range");
`endif

endmodule

>>> dv/area_weighted_entry_sampler_tb.sv
// ============================================================================
// area_weighted_entry_sampler_tb: self-checking bench for the entry sampler
// Drives clear, append, sample and no-op transactions with random gaps on both
// channels, predicts every result from a behavioral copy of the prefix-sum
// table and compares each output transaction field by field, in order.
// ============================================================================
module area_weighted_entry_sampler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import aws_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int AREA_W       = 32;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 4000;

    // Request kind that the block treats as a no-op.
    localparam t_req REQ_RESERVED = 2'd3;

    typedef struct {
        t_req        kind;
        logic [31:0] area;
        logic [31:0] draw;
        bit          held;
    } t_sampler_req;

    typedef struct {
        logic [7:0]  slot;
        logic [31:0] frac;
        logic [8:0]  count;
        t_status     code;
    } t_sampler_rsp;

    // Clock, reset and the block's ports.
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    t_req        i_req_type       = REQ_CLEAR;
    logic [31:0] i_entry_area     = '0;
    logic [31:0] i_uniform_sample = '0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [7:0]  o_chosen_index;
    logic [31:0] o_remapped_sample;
    logic [8:0]  o_entry_count;
    logic [1:0]  o_status;

    // Stimulus and expected results.
    t_sampler_req pending_requests[$];
    t_sampler_rsp awaited_results[$];
    t_sampler_req offered_req;
    bit           offering = 1'b0;

    // Behavioral copy of the prefix-sum table.
    logic [39:0] cdf_end [TABLE_DEPTH];
    int unsigned cdf_len   = 0;
    logic [39:0] cdf_total = '0;

    // Bookkeeping.
    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned n_clear      = 0;
    int unsigned n_append     = 0;
    int unsigned n_full       = 0;
    int unsigned n_sample     = 0;
    int unsigned n_empty      = 0;
    int unsigned n_other      = 0;
    int unsigned peak_len     = 0;
    int unsigned gen_len      = 0;
    int unsigned random_items = 0;

    area_weighted_entry_sampler #(
        .MAX_ENTRIES(TABLE_DEPTH),
        .AREA_BITS  (AREA_W)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_entry_area     (i_entry_area),
        .i_uniform_sample (i_uniform_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_chosen_index   (o_chosen_index),
        .o_remapped_sample(o_remapped_sample),
        .o_entry_count    (o_entry_count),
        .o_status         (o_status)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Idle length: mostly short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Areas come in styles so that some tables are all zero, some are tiny
    // with many empty entries and ties, and some span the full range.
    function automatic logic [31:0] pick_area(int unsigned style);
        int unsigned r;
        if (style == 0) return '0;
        if (style <= 2) return $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 40) return $urandom_range(1, 1000);
        if (r < 50) return '1;
        if (r < 60) return 32'd1 << $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_draw();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (r < 15) return $urandom_range(0, 255);
        if (r < 20) return ~32'($urandom_range(0, 255));
        return $urandom;
    endfunction

    task automatic queue_request(t_req kind, logic [31:0] area, logic [31:0] draw,
                                 bit held);
        t_sampler_req rq;
        rq.kind = kind;
        rq.area = area;
        rq.draw = draw;
        rq.held = held;
        pending_requests.insert(pending_requests.size(), rq);
        if (kind != REQ_RESERVED) random_items++;
        if (kind == REQ_CLEAR) gen_len = 0;
        else if (kind == REQ_APPEND && gen_len < TABLE_DEPTH) gen_len++;
    endtask

    // Result of one request against the table, updating the table as the
    // block does.
    function automatic t_sampler_rsp table_outcome(t_sampler_req rq);
        t_sampler_rsp rsp;
        logic [71:0]  product;
        logic [39:0]  scaled;
        logic [39:0]  lo_edge;
        logic [39:0]  width;
        logic [39:0]  offset;
        logic [71:0]  quotient;
        int unsigned  pick;
        rsp.slot = '0;
        rsp.frac = '0;
        rsp.code = STAT_OK;
        case (rq.kind)
            REQ_CLEAR: begin
                cdf_len   = 0;
                cdf_total = '0;
                n_clear++;
            end
            REQ_APPEND: begin
                n_append++;
                if (cdf_len >= TABLE_DEPTH) begin
                    rsp.code = STAT_FULL;
                    n_full++;
                end else begin
                    cdf_total        = cdf_total + 40'(rq.area[AREA_W-1:0]);
                    cdf_end[cdf_len] = cdf_total;
                    cdf_len++;
                    if (cdf_len > peak_len) peak_len = cdf_len;
                end
            end
            REQ_SAMPLE: begin
                n_sample++;
                if (cdf_len == 0 || cdf_total == '0) begin
                    rsp.code = STAT_EMPTY;
                    n_empty++;
                end else begin
                    product = 72'(rq.draw) * 72'(cdf_total);
                    scaled  = product[71:32];
                    // Last entry whose start is not above the scaled value;
                    // entry 0 always starts at zero.
                    pick = cdf_len - 1;
                    while (pick > 0 && cdf_end[pick-1] > scaled) pick--;
                    lo_edge  = (pick == 0) ? 40'd0 : cdf_end[pick-1];
                    width    = cdf_end[pick] - lo_edge;
                    rsp.slot = pick[7:0];
                    if (width == '0) begin
                        rsp.code = STAT_ZERO_AREA;
                    end else begin
                        offset = scaled - lo_edge;
                        if (offset >= width) begin
                            rsp.frac = '1;
                        end else begin
                            quotient = {offset, 32'd0} / 72'(width);
                            rsp.frac = quotient[31:0];
                        end
                    end
                end
            end
            default: begin
                n_other++;
            end
        endcase
        rsp.count = cdf_len[8:0];
        return rsp;
    endfunction

    // Input driver: presents queued requests with random gaps, and holds a
    // marked request back until every expected result has come out.
    always @(posedge i_clk) begin : drive_proc
        int unsigned gap_left;
        int unsigned calm_left;
        bit          keep;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left  = 0;
            calm_left = 0;
        end else begin
            keep = offering;
            if (i_in_valid && !o_in_stall) begin
                awaited_results.insert(awaited_results.size(), table_outcome(offered_req));
                keep = 1'b0;
                if (calm_left != 0) begin
                    calm_left--;
                    gap_left = 0;
                end else begin
                    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(30, 100);
                    gap_left = pick_gap();
                end
            end
            if (!keep) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_requests.size() != 0 &&
                             !(pending_requests[0].held && awaited_results.size() != 0)) begin
                    offered_req      = pending_requests.pop_front();
                    i_req_type       <= offered_req.kind;
                    i_entry_area     <= offered_req.area;
                    i_uniform_sample <= offered_req.draw;
                    keep = 1'b1;
                end
            end
            offering = keep;
            i_in_valid <= keep;
        end
    end

    // Output monitor: checks each result transaction and drives random stalls.
    always @(posedge i_clk) begin : watch_proc
        t_sampler_rsp want;
        int unsigned  stall_left;
        int unsigned  calm_out;
        bit           nxt_stall;
        if (!i_rst_n) begin
            stall_left = 0;
            calm_out   = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    if (o_chosen_index !== want.slot)
                        flag_error($sformatf("result %0d: chosen_index %0d, expected %0d",
                                             results_seen, o_chosen_index, want.slot));
                    if (o_remapped_sample !== want.frac)
                        flag_error($sformatf("result %0d: remapped_sample %h, expected %h",
                                             results_seen, o_remapped_sample, want.frac));
                    if (o_entry_count !== want.count)
                        flag_error($sformatf("result %0d: entry_count %0d, expected %0d",
                                             results_seen, o_entry_count, want.count));
                    if (o_status !== want.code)
                        flag_error($sformatf("result %0d: status %0d, expected %0d",
                                             results_seen, o_status, want.code));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else begin
                nxt_stall = 1'b0;
                if (calm_out != 0) begin
                    calm_out--;
                end else if ($urandom_range(0, 199) == 0) begin
                    calm_out = $urandom_range(100, 400);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                    if (stall_left != 0) begin
                        stall_left--;
                        nxt_stall = 1'b1;
                    end
                end
            end
            i_out_stall <= nxt_stall;
        end
    end

    // Watchdog on cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin : dog_proc
        int unsigned quiet;
        if (!i_rst_n) begin
            quiet = 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAIL area_weighted_entry_sampler");
                $finish;
            end
        end
    end

    initial begin : main_proc
        int unsigned episode;
        int unsigned style;
        int unsigned n;
        int unsigned r;
        bit          fill_table;

        // Directed: empty table, no-op kind, zero total, extreme areas and
        // draws, a zero-area entry that the search must skip, and clears.
        queue_request(REQ_SAMPLE,   '1, 32'h1234_5678, 1'b0);
        queue_request(REQ_RESERVED, '1, '1, 1'b0);
        queue_request(REQ_APPEND,   '0, '1, 1'b0);
        queue_request(REQ_SAMPLE,   '0, '1, 1'b0);
        queue_request(REQ_APPEND,   '1, '0, 1'b0);
        queue_request(REQ_APPEND,   32'd1, '0, 1'b0);
        queue_request(REQ_APPEND,   '0, '1, 1'b0);
        queue_request(REQ_APPEND,   32'h8000_0000, '0, 1'b0);
        queue_request(REQ_SAMPLE,   '0, '0, 1'b0);
        queue_request(REQ_SAMPLE,   '1, '1, 1'b0);
        queue_request(REQ_SAMPLE,   '0, 32'h8000_0000, 1'b0);
        queue_request(REQ_SAMPLE,   '1, 32'hFFFF_0000, 1'b0);
        queue_request(REQ_SAMPLE,   '0, 32'h7FFF_FFFF, 1'b0);
        queue_request(REQ_RESERVED, '0, '0, 1'b0);
        queue_request(REQ_CLEAR,    '1, '1, 1'b0);
        queue_request(REQ_SAMPLE,   '0, 32'h4000_0000, 1'b0);
        queue_request(REQ_APPEND,   32'h1234_5678, '1, 1'b0);
        queue_request(REQ_SAMPLE,   '1, 32'h5555_5555, 1'b0);
        queue_request(REQ_SAMPLE,   '0, 32'hAAAA_AAAA, 1'b0);
        queue_request(REQ_CLEAR,    '0, '0, 1'b0);

        // Random: build a table, then mostly sample it, with a few appends,
        // clears and no-op kinds mixed in. Some episodes fill the table past
        // its capacity.
        episode = 0;
        while (random_items < RANDOM_ITEMS + 20) begin
            episode++;
            fill_table = (episode == 3) || (episode == 11) || ($urandom_range(0, 39) == 0);
            style      = $urandom_range(0, 9);
            if (fill_table || $urandom_range(0, 5) != 0)
                queue_request(REQ_CLEAR, $urandom, $urandom,
                              (episode == 1) || ($urandom_range(0, 7) == 0));
            r = $urandom_range(0, 19);
            if (fill_table) n = TABLE_DEPTH - gen_len + $urandom_range(1, 3);
            else if (r < 12) n = $urandom_range(1, 8);
            else if (r < 17) n = $urandom_range(9, 40);
            else n = $urandom_range(41, 120);
            repeat (n) queue_request(REQ_APPEND, pick_area(style), $urandom, 1'b0);
            repeat ($urandom_range(4, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    queue_request(REQ_APPEND, pick_area(style), $urandom, 1'b0);
                else if (r < 10)
                    queue_request(REQ_RESERVED, $urandom, $urandom, 1'b0);
                else if (r < 12)
                    queue_request(REQ_CLEAR, $urandom, $urandom, 1'b0);
                else
                    queue_request(REQ_SAMPLE, $urandom, pick_draw(), 1'b0);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken and every result has come.
        while (pending_requests.size() != 0 || offering || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0)
            flag_error($sformatf("%0d expected results never arrived",
                                 awaited_results.size()));

        $display("Ran %0d clears, %0d appends (%0d refused on a full table), %0d no-ops,",
                 n_clear, n_append, n_full, n_other);
        $display("%0d samples (%0d on an empty or zero-weight table), peak of %0d entries.",
                 n_sample, n_empty, peak_len);
        if (errors == 0) begin
            $display("PASS area_weighted_entry_sampler");
        end else begin
            $display("FAIL area_weighted_entry_sampler");
        end
        $finish;
    end

endmodule

>>> area_weighted_entry_sampler.f
sv/aws_pkg.sv
sv/aws_prefix_ram.sv
sv/aws_scale_mul.sv
sv/aws_divider.sv
sv/area_weighted_entry_sampler.sv
dv/area_weighted_entry_sampler_tb.sv
